/* rtl/ptd_pkg.sv */
`default_nettype none

package ptd_pkg;

    // Framing
    localparam int unsigned PEN_PACKET_BYTES = 9;
    localparam int unsigned CNT_W            = 4;
    localparam int unsigned DATA_W           = 7;
    localparam int unsigned STORE_DEPTH      = 8;
    localparam int unsigned STORE_AW         = 3;
    localparam int unsigned PKT_DATA_BYTES   = 6;

    localparam logic [CNT_W-1:0] LEN_PEN       = CNT_W'(PEN_PACKET_BYTES);
    localparam logic [CNT_W-1:0] LEN_TOUCH     = CNT_W'(5);
    localparam logic [CNT_W-1:0] LEN_TOUCH_CAP = CNT_W'(7);

    // Header bit positions
    localparam int unsigned HB_SYNC    = 7;
    localparam int unsigned HB_CTRL    = 6;
    localparam int unsigned HB_PROX    = 5;
    localparam int unsigned HB_TOUCH   = 4;
    localparam int unsigned HB_TKIND   = 3;
    localparam int unsigned HB_CONTACT = 0;
    localparam int unsigned HB_ERASER  = 2;

    // Tool and channel codes
    localparam logic [1:0] TOOL_NONE   = 2'd0;
    localparam logic [1:0] TOOL_STYLUS = 2'd1;
    localparam logic [1:0] TOOL_ERASER = 2'd2;
    localparam logic [1:0] TOOL_TOUCH  = 2'd3;
    localparam logic       CH_PEN      = 1'b0;
    localparam logic       CH_TOUCH    = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_ENABLED      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_HAS_CAPACITY = 1'd1;

    // Queue between framer and decoder
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = 1;
    localparam int unsigned QUEUE_CW    = 2;

    typedef logic [DATA_W-1:0] t_data7;

    // One complete packet, d[0] is the first data byte after the header
    typedef struct packed {
        t_data7                       hdr;
        t_data7 [PKT_DATA_BYTES-1:0]  d;
        logic                         touch_en;
        logic                         touch_cap;
    } t_pkt;

    typedef struct packed {
        logic        channel;
        logic [1:0]  tool;
        logic        in_proximity;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [9:0]  pen_pressure;
        logic [13:0] touch_capacity;
        logic [2:0]  button_bits;
        logic        last_of_run;
    } t_report;

endpackage

`default_nettype wire

/* rtl/ptd_byte_if.sv */
`default_nettype none

interface ptd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/ptd_report_if.sv */
`default_nettype none

interface ptd_report_if;
    logic        valid;
    logic        ready;
    logic        channel;
    logic [1:0]  tool;
    logic        in_proximity;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [9:0]  pen_pressure;
    logic [13:0] touch_capacity;
    logic [2:0]  button_bits;
    logic        last_of_run;

    modport source (
        output valid, output channel, output tool, output in_proximity,
        output pos_x, output pos_y, output pen_pressure, output touch_capacity,
        output button_bits, output last_of_run, input ready
    );
    modport sink (
        input valid, input channel, input tool, input in_proximity,
        input pos_x, input pos_y, input pen_pressure, input touch_capacity,
        input button_bits, input last_of_run, output ready
    );
endinterface

`default_nettype wire

/* rtl/ptd_front.sv */
`default_nettype none

module ptd_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    ptd_byte_if.sink                           i_byte,
    input  wire logic                          i_cfg_we,
    input  wire logic [ptd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic                          i_cfg_wdata,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output ptd_pkg::t_pkt                      o_pkt
);
    import ptd_pkg::*;

    logic                r_cfg_en, r_cfg_cap;
    t_data7              r_hdr;
    logic [CNT_W-1:0]    r_cnt;
    t_data7              r_store [STORE_DEPTH];

    logic                w_accept, w_is_hdr, w_data, w_done;
    logic [CNT_W-1:0]    w_len, w_cnt_inc, w_cnt_dec;
    logic [STORE_AW-1:0] w_waddr;

    assign i_byte.ready = !i_q_full;
    assign w_accept  = i_byte.valid && i_byte.ready;
    assign w_is_hdr  = i_byte.rx_byte[HB_SYNC];
    assign w_cnt_inc = r_cnt + CNT_W'(1);
    assign w_cnt_dec = r_cnt - CNT_W'(1);
    assign w_waddr   = w_cnt_dec[STORE_AW-1:0];

    // length follows the open header and the capacity setting in force now
    assign w_len = (r_hdr[HB_TOUCH] || r_hdr[HB_TKIND])
                   ? (r_cfg_cap ? LEN_TOUCH_CAP : LEN_TOUCH) : LEN_PEN;

    assign w_data = w_accept && !w_is_hdr && (r_cnt != '0);
    assign w_done = w_data && (w_cnt_inc >= w_len);
    // control packets are dropped here
    assign o_push = w_done && !r_hdr[HB_CTRL];

    always_comb begin
        o_pkt.hdr       = r_hdr;
        o_pkt.touch_en  = r_cfg_en;
        o_pkt.touch_cap = r_cfg_cap;
        for (int i = 0; i < PKT_DATA_BYTES; i++) begin
            if (w_data && (w_waddr == STORE_AW'(i))) begin
                o_pkt.d[i] = i_byte.rx_byte[DATA_W-1:0];
            end else begin
                o_pkt.d[i] = r_store[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_en  <= 1'b1;
            r_cfg_cap <= 1'b0;
            r_hdr     <= '0;
            r_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TOUCH_ENABLED) begin
                    r_cfg_en <= i_cfg_wdata;
                end
                if (i_cfg_idx == CFG_TOUCH_HAS_CAPACITY) begin
                    r_cfg_cap <= i_cfg_wdata;
                end
            end
            if (w_accept && w_is_hdr) begin
                r_hdr <= i_byte.rx_byte[DATA_W-1:0];
                r_cnt <= CNT_W'(1);
            end else if (w_done) begin
                r_cnt <= '0;
            end else if (w_data) begin
                r_cnt <= w_cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_data) begin
            r_store[w_waddr] <= i_byte.rx_byte[DATA_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/ptd_queue.sv */
`default_nettype none

module ptd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ptd_pkg::t_pkt i_pkt,
    output logic               o_full,
    input  wire logic          i_pop,
    output ptd_pkg::t_pkt      o_pkt,
    output logic               o_empty
);
    import ptd_pkg::*;

    t_pkt                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_CW-1:0] r_cnt;

    assign o_full  = (r_cnt == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_pkt   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QUEUE_CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QUEUE_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_pkt;
        end
    end

endmodule

`default_nettype wire

/* rtl/ptd_back.sv */
`default_nettype none

module ptd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire ptd_pkg::t_pkt i_pkt,
    output logic               o_pop,
    ptd_report_if.source       o_report
);
    import ptd_pkg::*;

    // tracking state
    logic       r_tir, r_ppl, r_tpl;
    logic [1:0] r_ptk;
    logic       n_tir, n_ppl, n_tpl;
    logic [1:0] n_ptk;

    // reports still owed for the packet in hand
    logic       r_pend_tpo, r_pend_ppo, r_pend_main;
    logic       n_pend_tpo, n_pend_ppo, n_pend_main;
    t_report    r_main, n_main;

    t_report    r_out, w_sel;
    logic       r_out_valid;
    logic       w_any, w_load;

    assign w_any  = r_pend_tpo || r_pend_ppo || r_pend_main;
    assign o_pop  = !i_q_empty && !w_any;
    assign w_load = w_any && (!r_out_valid || o_report.ready);

    // packet decode and tracking update
    always_comb begin
        t_data7     h;
        t_data7     b6;
        logic [2:0] btn;
        logic [1:0] cur;
        logic [1:0] tk;
        logic       prox;

        h  = i_pkt.hdr;
        b6 = i_pkt.d[5];
        btn  = h[2:0];
        prox = h[HB_PROX];
        cur  = btn[HB_ERASER] ? TOOL_ERASER : TOOL_STYLUS;
        tk   = r_ptk;

        n_tir = r_tir;
        n_ppl = r_ppl;
        n_tpl = r_tpl;
        n_ptk = r_ptk;
        n_pend_tpo  = 1'b0;
        n_pend_ppo  = 1'b0;
        n_pend_main = 1'b0;
        n_main      = '0;

        if (h[HB_TOUCH] || h[HB_TKIND]) begin
            if ((r_ppl && (r_ptk != TOOL_NONE)) || !i_pkt.touch_en) begin
                // pen owns the surface or touch is disabled: only track touch range
                n_tir = !(h[HB_TOUCH] && !h[HB_CONTACT]);
            end else if (h[HB_TOUCH] && !(r_tir && h[HB_CONTACT])) begin
                n_tir                = 1'b0;
                n_tpl                = h[HB_CONTACT];
                n_pend_main          = 1'b1;
                n_main.channel       = CH_TOUCH;
                n_main.tool          = TOOL_TOUCH;
                n_main.in_proximity  = h[HB_CONTACT];
                n_main.pos_x         = {2'b00, i_pkt.d[0], i_pkt.d[1]};
                n_main.pos_y         = {2'b00, i_pkt.d[2], i_pkt.d[3]};
                n_main.touch_capacity = i_pkt.touch_cap ? {i_pkt.d[4], i_pkt.d[5]} : '0;
                n_main.button_bits   = {2'b00, h[HB_CONTACT]};
            end
        end else begin
            n_pend_tpo = r_tpl;
            n_tpl      = 1'b0;
            if (!r_ppl && prox) begin
                tk = cur;
            end else if ((btn != '0) && prox) begin
                if ((r_ptk != cur) && (r_ptk == TOOL_ERASER)) begin
                    n_pend_ppo = 1'b1;
                    tk         = cur;
                end
            end
            n_ptk = tk;
            n_ppl = prox;
            n_pend_main         = 1'b1;
            n_main.channel      = CH_PEN;
            n_main.tool         = tk;
            n_main.in_proximity = prox;
            n_main.pos_x        = {i_pkt.d[0], i_pkt.d[1], b6[6:5]};
            n_main.pos_y        = {i_pkt.d[2], i_pkt.d[3], b6[4:3]};
            n_main.pen_pressure = {b6[2:0], i_pkt.d[4]};
            n_main.button_bits  = ((tk == TOOL_ERASER) && btn[HB_ERASER]) ? 3'b000 : btn;
        end
    end

    // pick next owed report: touch prox-out, pen prox-out, then main
    always_comb begin
        w_sel = '0;
        if (r_pend_tpo) begin
            w_sel.channel     = CH_TOUCH;
            w_sel.tool        = TOOL_TOUCH;
            w_sel.last_of_run = !(r_pend_ppo || r_pend_main);
        end else if (r_pend_ppo) begin
            w_sel.channel     = CH_PEN;
            w_sel.tool        = TOOL_NONE;
            w_sel.last_of_run = !r_pend_main;
        end else begin
            w_sel             = r_main;
            w_sel.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tir       <= 1'b0;
            r_ppl       <= 1'b0;
            r_tpl       <= 1'b0;
            r_ptk       <= TOOL_NONE;
            r_pend_tpo  <= 1'b0;
            r_pend_ppo  <= 1'b0;
            r_pend_main <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_tir       <= n_tir;
                r_ppl       <= n_ppl;
                r_tpl       <= n_tpl;
                r_ptk       <= n_ptk;
                r_pend_tpo  <= n_pend_tpo;
                r_pend_ppo  <= n_pend_ppo;
                r_pend_main <= n_pend_main;
            end else if (w_load) begin
                if (r_pend_tpo) begin
                    r_pend_tpo <= 1'b0;
                end else if (r_pend_ppo) begin
                    r_pend_ppo <= 1'b0;
                end else begin
                    r_pend_main <= 1'b0;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_report.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_main <= n_main;
        end
        if (w_load) begin
            r_out <= w_sel;
        end
    end

    assign o_report.valid          = r_out_valid;
    assign o_report.channel        = r_out.channel;
    assign o_report.tool           = r_out.tool;
    assign o_report.in_proximity   = r_out.in_proximity;
    assign o_report.pos_x          = r_out.pos_x;
    assign o_report.pos_y          = r_out.pos_y;
    assign o_report.pen_pressure   = r_out.pen_pressure;
    assign o_report.touch_capacity = r_out.touch_capacity;
    assign o_report.button_bits    = r_out.button_bits;
    assign o_report.last_of_run    = r_out.last_of_run;

endmodule

`default_nettype wire

/* rtl/pen_touch_packet_decoder.sv */
// The first report of a packet passes the packet queue, the pending registers and the
//   output register; further reports of it follow one a cycle while the sink is ready.
// Throughput: one byte per cycle unless the queue is full; a packet (5 to 9 bytes)
//   gives at most three reports; it keeps up while the sink takes one report per cycle.
// Reset: synchronous, active low; clears framing, pen/touch tracking, queue and output,
//   and sets touch_enabled = 1, touch_has_capacity = 0.
`default_nettype none

module pen_touch_packet_decoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    ptd_byte_if.sink                           i_byte,
    ptd_report_if.source                       o_report,
    input  wire logic                          i_cfg_we,
    input  wire logic [ptd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic                          i_cfg_wdata
);
    import ptd_pkg::*;

    // front (framer) -> queue
    logic w_push;
    t_pkt w_push_pkt;
    logic w_q_full;

    // queue -> back (decoder)
    logic w_pop;
    t_pkt w_pop_pkt;
    logic w_q_empty;

    // Framer: takes bytes, collects data bytes behind a header, drops control
    // packets and hands each complete packet (with config snapshot) to the queue.
    ptd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_pkt       (w_push_pkt)
    );

    // Two-packet queue so framing and report output stall independently.
    ptd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pkt   (w_push_pkt),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_pkt   (w_pop_pkt),
        .o_empty (w_q_empty)
    );

    // Decoder: pen/touch arbitration, tool tracking, report sequencing into
    // a registered output stage.
    ptd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_pkt     (w_pop_pkt),
        .o_pop     (w_pop),
        .o_report  (o_report)
    );

    // never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("packet queue overflow");

    // never pop an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("packet queue underflow");

    // control packets never reach the decoder
    a_no_ctrl_pkt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_push_pkt.hdr[HB_CTRL])
        else $error("control packet queued");

    // a run of reports is not broken up by bubbles
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_report.valid && o_report.ready && !o_report.last_of_run) |=> o_report.valid)
        else $error("gap inside a report run");

endmodule

`default_nettype wire

/* tb/tb_pen_touch_packet_decoder.sv */
`timescale 1ns / 1ps

import ptd_pkg::*;

// Tracks framing and pen/touch state and queues the reports each byte must produce.
class report_scoreboard;
    bit        touch_en;
    bit        touch_cap;
    t_data7    pkt_data [STORE_DEPTH];
    t_data7    hdr;
    bit [3:0]  bytes_in;
    bit        touch_in_range;
    bit        pen_prox_last;
    bit [1:0]  pen_tool;
    bit        touch_prox_last;
    t_report   expected_reports [$];
    int        errors;

    function new();
        touch_en        = 1'b1;
        touch_cap       = 1'b0;
        hdr             = '0;
        bytes_in        = '0;
        touch_in_range  = 1'b0;
        pen_prox_last   = 1'b0;
        pen_tool        = TOOL_NONE;
        touch_prox_last = 1'b0;
        errors          = 0;
        foreach (pkt_data[i]) pkt_data[i] = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, bit val);
        if (idx == CFG_TOUCH_ENABLED) begin
            touch_en = val;
        end else if (idx == CFG_TOUCH_HAS_CAPACITY) begin
            touch_cap = val;
        end
    endfunction

    function int pending();
        return expected_reports.size();
    endfunction

    function void push_report(logic ch, logic [1:0] tool, logic prox, logic [15:0] x,
                              logic [15:0] y, logic [9:0] pr, logic [13:0] cap,
                              logic [2:0] btn);
        t_report r;
        r.channel        = ch;
        r.tool           = tool;
        r.in_proximity   = prox;
        r.pos_x          = x;
        r.pos_y          = y;
        r.pen_pressure   = pr;
        r.touch_capacity = cap;
        r.button_bits    = btn;
        r.last_of_run    = 1'b0;
        expected_reports.push_back(r);
    endfunction

    function void decode_touch_packet();
        logic [13:0] cap;
        bit          contact;
        cap     = '0;
        contact = hdr[HB_CONTACT];
        if ((pen_prox_last && pen_tool != TOOL_NONE) || !touch_en) begin
            // suppressed: only remember whether touch is still in range
            touch_in_range = !(hdr[HB_TOUCH] && !contact);
            return;
        end
        if (!hdr[HB_TOUCH]) return;
        if (touch_in_range) begin
            if (contact) return;
            touch_in_range = 1'b0;
        end
        if (touch_cap) cap = {pkt_data[4], pkt_data[5]};
        touch_prox_last = contact;
        push_report(CH_TOUCH, TOOL_TOUCH, contact, 16'({pkt_data[0], pkt_data[1]}),
                    16'({pkt_data[2], pkt_data[3]}), '0, cap, {2'b00, contact});
    endfunction

    function void decode_pen_packet();
        t_data7     b6;
        bit         prox;
        logic [2:0] btn;
        bit [1:0]   cur;
        b6   = pkt_data[5];
        prox = hdr[HB_PROX];
        btn  = hdr[2:0];
        cur  = btn[HB_ERASER] ? TOOL_ERASER : TOOL_STYLUS;
        if (touch_prox_last) begin
            push_report(CH_TOUCH, TOOL_TOUCH, 1'b0, '0, '0, '0, '0, '0);
            touch_prox_last = 1'b0;
        end
        if (!pen_prox_last && prox) begin
            pen_tool = cur;
        end else if (btn != 0 && prox) begin
            if (pen_tool != cur && pen_tool == TOOL_ERASER) begin
                push_report(CH_PEN, TOOL_NONE, 1'b0, '0, '0, '0, '0, '0);
                pen_tool = cur;
            end
        end
        if (pen_tool == TOOL_ERASER && btn[HB_ERASER]) btn = '0;
        pen_prox_last = prox;
        push_report(CH_PEN, pen_tool, prox, {pkt_data[0], pkt_data[1], b6[6:5]},
                    {pkt_data[2], pkt_data[3], b6[4:3]}, {b6[2:0], pkt_data[4]}, '0, btn);
    endfunction

    // Called on every byte transfer into the block.
    function void note_byte(logic [7:0] b);
        bit [3:0] need;
        int       n0;
        t_report  r;
        if (b[HB_SYNC]) begin
            hdr      = b[6:0];
            bytes_in = 4'd1;
        end else begin
            if (bytes_in == 0) return;
            pkt_data[3'(bytes_in - 4'd1)] = b[6:0];
            bytes_in++;
        end
        need = (hdr[HB_TOUCH] || hdr[HB_TKIND]) ? (touch_cap ? LEN_TOUCH_CAP : LEN_TOUCH)
                                                : LEN_PEN;
        if (bytes_in < need) return;
        bytes_in = '0;
        if (hdr[HB_CTRL]) return;
        n0 = expected_reports.size();
        if (hdr[HB_TOUCH] || hdr[HB_TKIND]) begin
            decode_touch_packet();
        end else begin
            decode_pen_packet();
        end
        if (expected_reports.size() > n0) begin
            r = expected_reports.pop_back();
            r.last_of_run = 1'b1;
            expected_reports.push_back(r);
        end
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_report(t_report got);
        t_report want;
        if (expected_reports.size() == 0) begin
            $error("unexpected report: channel %0d tool %0d", got.channel, got.tool);
            errors++;
            return;
        end
        want = expected_reports.pop_front();
        check_field("channel", want.channel, got.channel);
        check_field("tool", want.tool, got.tool);
        check_field("in_proximity", want.in_proximity, got.in_proximity);
        check_field("pos_x", want.pos_x, got.pos_x);
        check_field("pos_y", want.pos_y, got.pos_y);
        check_field("pen_pressure", want.pen_pressure, got.pen_pressure);
        check_field("touch_capacity", want.touch_capacity, got.touch_capacity);
        check_field("button_bits", want.button_bits, got.button_bits);
        check_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
endclass

module tb_pen_touch_packet_decoder;

    // Run sizing: random stimulus stops once this many bytes of real packets went in.
    localparam int unsigned RANDOM_ITEMS = 230;
    // Report path runs through the two-entry packet queue and the output register; settle well past it.
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PEN_DATA     = PEN_PACKET_BYTES - 1;
    localparam int unsigned NUM_PHASES   = 7;

    // Receiver stall behaviors, switched at random by the report sink.
    typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_SLOW, RX_PERIODIC} t_rx_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic                 i_cfg_wdata;

    ptd_byte_if   byte_ch ();
    ptd_report_if report_ch ();

    pen_touch_packet_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (byte_ch),
        .o_report    (report_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    report_scoreboard sb;

    // Planned bytes: bit 8 marks bytes of well-formed packets, which count toward the run.
    logic [8:0]  byte_plan [$];
    int unsigned burst_left;
    int unsigned counted_bytes;
    bit          cfg_touch_cap;

    // Config sequence for the random phases; covers all four combinations.
    bit phase_te [NUM_PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    bit phase_tc [NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

    t_report     observed;
    t_rx_mode    rx_mode;
    int unsigned rx_tick;
    int unsigned cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a report that never shows up ends here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    //--------------------------------------------------------------------
    // Report sink: check each transfer, then pick next cycle's ready.
    //--------------------------------------------------------------------
    initial begin
        report_ch.ready <= 1'b0;
        rx_mode = RX_STREAM;
        rx_tick = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && report_ch.valid && report_ch.ready) begin
                observed.channel        = report_ch.channel;
                observed.tool           = report_ch.tool;
                observed.in_proximity   = report_ch.in_proximity;
                observed.pos_x          = report_ch.pos_x;
                observed.pos_y          = report_ch.pos_y;
                observed.pen_pressure   = report_ch.pen_pressure;
                observed.touch_capacity = report_ch.touch_capacity;
                observed.button_bits    = report_ch.button_bits;
                observed.last_of_run    = report_ch.last_of_run;
                sb.check_report(observed);
            end
            rx_tick++;
            if (rx_tick % 40 == 0) rx_mode = t_rx_mode'($urandom_range(0, 3));
            case (rx_mode)
                RX_STREAM: begin
                    report_ch.ready <= 1'b1;
                end
                RX_RANDOM: begin
                    report_ch.ready <= 1'($urandom_range(0, 1));
                end
                RX_SLOW: begin
                    report_ch.ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    // periodic: ready follows bit 2 of rx_tick
                    report_ch.ready <= rx_tick[2];
                end
            endcase
        end
    end

    //--------------------------------------------------------------------
    // Byte source
    //--------------------------------------------------------------------

    // Bursts of random length; a gap before a burst, when one is drawn, lowers valid.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                byte_ch.valid   <= 1'b0;
                byte_ch.rx_byte <= 8'($urandom);
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        // transfer happened at this edge
        sb.note_byte(b);
        burst_left--;
    endtask

    function automatic logic [7:0] data_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'h7F;
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic logic [7:0] pen_header(bit prox, logic [2:0] btn);
        logic [7:0] h;
        h          = '0;
        h[HB_SYNC] = 1'b1;
        h[HB_PROX] = prox;
        h[2:0]     = btn;
        return h;
    endfunction

    // Mostly plain touch headers; now and then the odd type bit combinations.
    function automatic logic [7:0] touch_header(bit contact);
        logic [7:0] h;
        h          = 8'($urandom_range(0, 127));
        h[HB_SYNC] = 1'b1;
        h[HB_CTRL] = 1'b0;
        if ($urandom_range(0, 6) != 0) begin
            h[HB_TOUCH] = 1'b1;
            h[HB_TKIND] = 1'b0;
        end else if (h[HB_TOUCH:HB_TKIND] == 2'b00) begin
            h[HB_TKIND] = 1'b1;
        end
        h[HB_CONTACT] = contact;
        return h;
    endfunction

    function automatic int unsigned touch_packet_len();
        return cfg_touch_cap ? LEN_TOUCH_CAP : LEN_TOUCH;
    endfunction

    function automatic void plan_packet(logic [7:0] h, int unsigned n_data, bit counts);
        byte_plan.push_back({counts, h});
        repeat (n_data) byte_plan.push_back({counts, data_byte()});
    endfunction

    // One scenario: a pen stroke, a touch run, or some noise.
    function automatic void plan_episode();
        int unsigned r;
        int unsigned n;
        int unsigned len;
        bit          eraser;
        logic [2:0]  btn;
        logic [7:0]  h;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            // stroke in proximity, tool may flip stylus <-> eraser mid-stroke
            n      = $urandom_range(1, 4);
            eraser = 1'($urandom_range(0, 1));
            repeat (n) begin
                if ($urandom_range(0, 3) == 0) eraser = !eraser;
                btn = eraser ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
                plan_packet(pen_header(1'b1, btn), PEN_DATA, 1'b1);
            end
            if ($urandom_range(0, 9) < 6)
                plan_packet(pen_header(1'b0, 3'($urandom)), PEN_DATA, 1'b1);
        end else if (r < 80) begin
            // contacts, usually ending with a lift
            n = $urandom_range(1, 4);
            repeat (n - 1) plan_packet(touch_header(1'b1), touch_packet_len() - 1, 1'b1);
            plan_packet(touch_header($urandom_range(0, 9) < 3), touch_packet_len() - 1, 1'b1);
        end else if (r < 88) begin
            // control packet, length follows the type bits
            h          = 8'($urandom_range(0, 127));
            h[HB_SYNC] = 1'b1;
            h[HB_CTRL] = 1'b1;
            len = (h[HB_TOUCH] || h[HB_TKIND]) ? touch_packet_len() : PEN_PACKET_BYTES;
            plan_packet(h, len - 1, 1'b0);
        end else if (r < 94) begin
            // packet cut short by the next header
            if ($urandom_range(0, 1)) begin
                h   = pen_header(1'($urandom_range(0, 1)), 3'($urandom));
                len = PEN_PACKET_BYTES;
            end else begin
                h   = touch_header(1'($urandom_range(0, 1)));
                len = touch_packet_len();
            end
            plan_packet(h, $urandom_range(0, len - 2), 1'b0);
        end else begin
            // loose data bytes
            n = $urandom_range(1, 3);
            repeat (n) byte_plan.push_back({1'b0, data_byte()});
        end
    endfunction

    // Sends until 'target' counted bytes went in; target 0 flushes the plan.
    // Whatever is left of a packet carries over into the next phase.
    task automatic run_phase(input int unsigned target);
        int unsigned sent;
        logic [8:0]  entry;
        sent = 0;
        while (sent < target || (target == 0 && byte_plan.size() > 0)) begin
            if (byte_plan.size() == 0) plan_episode();
            entry = byte_plan.pop_front();
            send_byte(entry[7:0]);
            if (entry[8]) begin
                sent++;
                counted_bytes++;
            end
        end
        byte_ch.valid <= 1'b0;
    endtask

    // Idle point: every expected report in, then let a dropped packet settle.
    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Both registers, back to back, write enable held while both are written.
    task automatic write_config(input bit te, input bit tc);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_TOUCH_ENABLED;
        i_cfg_wdata <= te;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_TOUCH_HAS_CAPACITY;
        i_cfg_wdata <= tc;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_register(CFG_TOUCH_ENABLED, te);
        sb.set_register(CFG_TOUCH_HAS_CAPACITY, tc);
        cfg_touch_cap = tc;
    endtask

    //--------------------------------------------------------------------
    // Main sequence
    //--------------------------------------------------------------------
    initial begin
        int unsigned phase;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_TOUCH_ENABLED;
        i_cfg_wdata     <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.rx_byte <= '0;
        sb            = new();
        burst_left    = 0;
        counted_bytes = 0;
        cfg_touch_cap = 1'b0;
        phase         = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset config: stray data byte with nothing open; pen packet out
        // of proximity before any tool (all-ones data); all-ones control header;
        // eraser entering with the eraser button set (buttons read back as zero).
        byte_plan.push_back({1'b0, 8'h00});
        byte_plan.push_back({1'b0, pen_header(1'b0, 3'b000)});
        repeat (PEN_DATA) byte_plan.push_back({1'b0, 8'h7F});
        byte_plan.push_back({1'b0, 8'hFF});
        repeat (LEN_TOUCH - 1) byte_plan.push_back({1'b0, 8'h00});
        byte_plan.push_back({1'b0, pen_header(1'b1, 3'b110)});
        repeat (PEN_DATA / 2) begin
            byte_plan.push_back({1'b0, 8'h55});
            byte_plan.push_back({1'b0, 8'h2A});
        end
        run_phase(0);
        drain();

        // Random phases, config changed at each idle point (packets may straddle it).
        while (counted_bytes < RANDOM_ITEMS) begin
            write_config(phase_te[phase % NUM_PHASES], phase_tc[phase % NUM_PHASES]);
            run_phase($urandom_range(25, 50));
            drain();
            phase++;
        end
        run_phase(0);
        drain();

        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
